// File: src/nth_pkg.sv
`default_nettype none

package nth_pkg;

    localparam int REQ_W   = 3;
    localparam int DEV_W   = 16;
    localparam int NODE_W  = 48;
    localparam int SIZE_W  = 48;
    localparam int LIVE_W  = 11;
    localparam int BYTES_W = 56;
    localparam int ACC_W   = BYTES_W + 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_UPDATE = 3'd2,
        REQ_FIND   = 3'd3,
        REQ_CLEAR  = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_ADD,
        ST_EXEC,
        ST_DONE,
        ST_SWEEP
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [DEV_W-1:0]  dev;
        logic [NODE_W-1:0] node;
        logic [SIZE_W-1:0] size;
    } slot_t;

endpackage

`default_nettype wire

// File: src/node_tracking_hash_table.sv
`default_nettype none

// channel | handshake            | word
// --------+----------------------+---------------------------------------------
// in      | in_valid / in_stall  | req_type, device_id, node_id, new_size
// out     | out_valid / out_stall| found, prior_size, status, live_entries,
//         |                      | live_bytes
//
// A request scans its bucket one way at a time through the slot RAM (read,
// then compare); an update makes two passes through the totals adder. Clear
// all adds a sweep that clears all BUCKETS*WAYS slots. After reset the same
// sweep runs before the first word is taken. The output register lets a new
// word in while a result waits; a stalled output holds the sequencer only at
// its final step.

module node_tracking_hash_table #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [nth_pkg::REQ_W-1:0]    req_type,
    input  wire logic [nth_pkg::DEV_W-1:0]    device_id,
    input  wire logic [nth_pkg::NODE_W-1:0]   node_id,
    input  wire logic [nth_pkg::SIZE_W-1:0]   new_size,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              found,
    output logic      [nth_pkg::SIZE_W-1:0]   prior_size,
    output logic                              status,
    output logic      [nth_pkg::LIVE_W-1:0]   live_entries,
    output logic      [nth_pkg::BYTES_W-1:0]  live_bytes
);

    import nth_pkg::*;

    localparam int SLOTS = BUCKETS * WAYS;
    localparam int AW    = $clog2(SLOTS);
    localparam int BK_W  = $clog2(BUCKETS);
    localparam int WY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int SW    = $bits(slot_t);

    state_t state_reg, state_next;

    logic [REQ_W-1:0]   req_reg;
    logic [DEV_W-1:0]   dev_reg;
    logic [NODE_W-1:0]  node_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [WY_W-1:0]    way_reg;
    logic               hit_reg;
    logic [WY_W-1:0]    hit_way_reg;
    logic               free_reg;
    logic [WY_W-1:0]    free_way_reg;
    logic [SIZE_W-1:0]  prior_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [BYTES_W-1:0] total_reg;
    logic [AW-1:0]      sweep_reg;

    logic               out_valid_reg;
    logic               found_reg;
    logic [SIZE_W-1:0]  prior_out_reg;
    logic               status_reg;
    logic [LIVE_W-1:0]  live_entries_reg;
    logic [BYTES_W-1:0] live_bytes_reg;

    logic               accept;
    logic               out_free;
    logic               way_last;
    logic               sweep_last;
    logic [AW-1:0]      base_addr;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    slot_t              ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [SW-1:0]      ram_rdata;
    slot_t              rd_slot;

    logic signed [ACC_W-1:0] alu_a;
    logic signed [ACC_W-1:0] alu_b;
    logic                    alu_sub;
    logic signed [ACC_W-1:0] alu_raw;
    logic [BYTES_W-1:0]      alu_clamped;

    logic               ins_ok;
    logic               ins_full;
    logic               key_match;

    nth_ram #(
        .WIDTH(SW),
        .DEPTH(SLOTS)
    ) u_slots (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    nth_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .sub    (alu_sub),
        .raw    (alu_raw),
        .clamped(alu_clamped)
    );

    assign rd_slot    = slot_t'(ram_rdata);
    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign way_last   = (way_reg == WY_W'(WAYS - 1));
    assign sweep_last = (sweep_reg == AW'(SLOTS - 1));
    assign base_addr  = AW'(AW'(node_reg[BK_W-1:0]) * AW'(WAYS));
    assign key_match  = (rd_slot.dev == dev_reg) && (rd_slot.node == node_reg);
    assign ins_ok     = !hit_reg && free_reg;
    assign ins_full   = !hit_reg && !free_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                priority if (!way_last)
                begin
                    state_next = ST_RD;
                end
                else if (req_reg == REQ_UPDATE)
                begin
                    state_next = ST_ADD;
                end
                else
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_ADD:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = (req_reg == REQ_CLEAR) ? ST_SWEEP : ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        ram_we    = 1'b0;
        ram_waddr = AW'(base_addr + AW'(hit_way_reg));
        ram_wdata = '{valid: 1'b1, dev: dev_reg, node: node_reg, size: size_reg};
        ram_raddr = AW'(base_addr + AW'(way_reg));
        alu_a     = $signed({2'b00, total_reg});
        alu_b     = $signed({{(ACC_W - SIZE_W){1'b0}}, size_reg});
        alu_sub   = 1'b0;
        unique case (state_reg)
            ST_EXEC:
            begin
                case (req_reg)
                    REQ_INSERT:
                    begin
                        ram_we    = ins_ok;
                        ram_waddr = AW'(base_addr + AW'(free_way_reg));
                    end
                    REQ_REMOVE:
                    begin
                        ram_we          = hit_reg;
                        ram_wdata.valid = 1'b0;
                        alu_b           = $signed({{(ACC_W - SIZE_W){1'b0}}, prior_reg});
                        alu_sub         = 1'b1;
                    end
                    REQ_UPDATE:
                    begin
                        ram_we  = hit_reg;
                        alu_a   = acc_reg;
                        alu_b   = $signed({{(ACC_W - SIZE_W){1'b0}}, prior_reg});
                        alu_sub = 1'b1;
                    end
                    default:
                    begin
                        ram_we = 1'b0;
                    end
                endcase
            end
            ST_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = '0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_reg     <= '0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            way_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        way_reg  <= '0;
                        hit_reg  <= 1'b0;
                        free_reg <= 1'b0;
                    end
                end
                ST_CMP:
                begin
                    if (rd_slot.valid)
                    begin
                        if (!hit_reg && key_match)
                        begin
                            hit_reg <= 1'b1;
                        end
                    end
                    else if (!free_reg)
                    begin
                        free_reg <= 1'b1;
                    end
                    if (!way_last)
                    begin
                        way_reg <= WY_W'(way_reg + 1'b1);
                    end
                end
                ST_EXEC:
                begin
                    case (req_reg)
                        REQ_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                cnt_reg   <= CNT_W'(cnt_reg + 1'b1);
                                total_reg <= alu_clamped;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (hit_reg)
                            begin
                                if (cnt_reg != '0)
                                begin
                                    cnt_reg <= CNT_W'(cnt_reg - 1'b1);
                                end
                                total_reg <= alu_clamped;
                            end
                        end
                        REQ_UPDATE:
                        begin
                            if (hit_reg)
                            begin
                                total_reg <= alu_clamped;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            cnt_reg   <= '0;
                            total_reg <= '0;
                        end
                        default:
                        begin
                            cnt_reg <= cnt_reg;
                        end
                    endcase
                end
                ST_SWEEP:
                begin
                    sweep_reg <= sweep_last ? '0 : AW'(sweep_reg + 1'b1);
                end
                default:
                begin
                    way_reg <= way_reg;
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            dev_reg   <= device_id;
            node_reg  <= node_id;
            size_reg  <= new_size;
            prior_reg <= '0;
        end
        if (state_reg == ST_CMP)
        begin
            if (rd_slot.valid)
            begin
                if (!hit_reg && key_match)
                begin
                    hit_way_reg <= way_reg;
                    prior_reg   <= rd_slot.size;
                end
            end
            else if (!free_reg)
            begin
                free_way_reg <= way_reg;
            end
        end
        if (state_reg == ST_ADD)
        begin
            acc_reg <= alu_raw;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            found_reg        <= hit_reg;
            prior_out_reg    <= prior_reg;
            status_reg       <= (req_reg == REQ_INSERT) && ins_full;
            live_entries_reg <= LIVE_W'(cnt_reg);
            live_bytes_reg   <= total_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign prior_size   = prior_out_reg;
    assign status       = status_reg;
    assign live_entries = live_entries_reg;
    assign live_bytes   = live_bytes_reg;

endmodule

`default_nettype wire

// File: src/nth_ram.sv
`default_nettype none

module nth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/nth_alu.sv
`default_nettype none

module nth_alu (
    input  wire logic signed [nth_pkg::ACC_W-1:0]   a,
    input  wire logic signed [nth_pkg::ACC_W-1:0]   b,
    input  wire logic                               sub,
    output logic signed      [nth_pkg::ACC_W-1:0]   raw,
    output logic             [nth_pkg::BYTES_W-1:0] clamped
);

    import nth_pkg::*;

    assign raw = sub ? (a - b) : (a + b);

    // clamp to [0, 2^BYTES_W - 1]
    always_comb
    begin
        priority if (raw[ACC_W-1])
        begin
            clamped = '0;
        end
        else if (raw[ACC_W-2:BYTES_W] != '0)
        begin
            clamped = '1;
        end
        else
        begin
            clamped = raw[BYTES_W-1:0];
        end
    end

endmodule

`default_nettype wire
